@@ sv/txcon_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// txcon_pkg
// Shared types and constants of the text console cursor engine.
// ----------------------------------------------------------------------------
package txcon_pkg;

	localparam int CHAR_W     = 8;
	localparam int CELL_SHIFT = 3;   // 8x8 character cell

	localparam logic [CHAR_W-1:0] CHAR_NL    = 8'h0A;
	localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] CHAR_FIRST = 8'h20;
	localparam logic [CHAR_W-1:0] CHAR_LAST  = 8'h7E;
	localparam logic [6:0]        GLYPH_FALLBACK = 7'd95;

	typedef enum logic [1:0] {
		OP_DRAW   = 2'd0,
		OP_SCROLL = 2'd1,
		OP_CLEAR  = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		CFG_SCALE      = 3'd0,
		CFG_COLUMNS    = 3'd1,
		CFG_ROWS       = 3'd2,
		CFG_TAB_STOP   = 3'd3,
		CFG_FOREGROUND = 3'd4,
		CFG_BACKGROUND = 3'd5
	} cfg_idx_t;

	// status of the remainder unit
	typedef struct packed {
		logic busy;
		logic done;
	} rem_stat_t;

endpackage

@@ sv/txcon_rem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// txcon_rem
// Restoring remainder unit: one shared compare/subtract, one dividend bit a
// cycle, all CHAR_W dividend bits per operation; start is ignored while busy.
// ----------------------------------------------------------------------------
module txcon_rem import txcon_pkg::*; #(
	parameter int DW = 5
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [CHAR_W-1:0]   dividend,
	input  logic [DW-1:0]       divisor,
	output rem_stat_t           stat,
	output logic [DW-1:0]       rem
);

	localparam int BW = $clog2(CHAR_W);

	logic [CHAR_W-1:0] dvd_q;
	logic [DW-1:0]     div_q;
	logic [DW-1:0]     r_q;
	logic [BW-1:0]     bit_q;
	logic              busy_q;
	logic              done_q;

	logic [DW:0] trial;
	logic [DW:0] diff;
	logic        fits;

	assign trial = {r_q, dvd_q[CHAR_W-1]};
	assign fits  = trial >= {1'b0, div_q};
	assign diff  = trial - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			bit_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (busy_q) begin
				r_q   <= fits ? diff[DW-1:0] : trial[DW-1:0];
				dvd_q <= {dvd_q[CHAR_W-2:0], 1'b0};
				bit_q <= bit_q - BW'(1);
				if (bit_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end else if (start) begin
				dvd_q  <= dividend;
				div_q  <= divisor;
				r_q    <= '0;
				bit_q  <= BW'(CHAR_W - 1);
				busy_q <= 1'b1;
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign rem       = r_q;

	a_rem_below_div: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> r_q < div_q)
		else $error("remainder not below divisor");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy_q) |=> busy_q)
		else $error("start not taken");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("done longer than one cycle");

endmodule

@@ sv/text_console_cursor_engine_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_cursor_engine_top
// Character stream in, framebuffer commands out (draw cell, scroll, clear row).
// ----------------------------------------------------------------------------
// channel | dir | handshake           | payload
// s_*     | in  | s_tvalid / s_tready | tdata: char_code
// m_*     | out | m_tvalid / m_tready | tdata: cell geometry + colors,
//         |     |                     | tuser: op, tlast: last command
// cfg_*   | in  | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One character at a time; s_tready is low while a character is at work.
// Newline: no beat, plus 2 beats (scroll, clear row) when it scrolls. Other
// bytes: 1 draw beat (+2 beats on scroll). Tab: the remainder unit takes the
// column one bit a cycle, then the space count is taken, then one beat per
// space and 2 per scroll.
// No clearing pass after reset. A stalled m_tready holds the sequencer.
// ----------------------------------------------------------------------------
module text_console_cursor_engine_top import txcon_pkg::*; #(
	parameter int MAX_TAB_STOP = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [7:0]    s_tdata,     // [7:0] char_code
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [111:0]  m_tdata,     // [13:0] pixel_x, [27:14] pixel_y,
	                                   // [34:28] glyph, [41:35] scroll_pixels,
	                                   // [73:42] fg_color, [105:74] bg_color
	output logic [1:0]    m_tuser,     // [1:0] op
	output logic          m_tlast,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [2:0]    cfg_index,
	input  logic [31:0]   cfg_data
);

	localparam int TW = $clog2(MAX_TAB_STOP + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REM,
		ST_DRAW,
		ST_SCROLL,
		ST_CLEAR
	} state_t;

	// configuration
	logic [3:0]  scale_q;
	logic [7:0]  columns_q;
	logic [7:0]  rows_q;
	logic [4:0]  tab_stop_q;
	logic [31:0] fg_q;
	logic [31:0] bg_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q    <= 4'd1;
			columns_q  <= 8'd80;
			rows_q     <= 8'd30;
			tab_stop_q <= 5'd8;
			fg_q       <= 32'hFFFF_FFFF;
			bg_q       <= 32'h0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				CFG_SCALE:      scale_q    <= cfg_data[3:0];
				CFG_COLUMNS:    columns_q  <= cfg_data[7:0];
				CFG_ROWS:       rows_q     <= cfg_data[7:0];
				CFG_TAB_STOP:   tab_stop_q <= cfg_data[4:0];
				CFG_FOREGROUND: fg_q       <= cfg_data;
				CFG_BACKGROUND: bg_q       <= cfg_data;
				default: ;
			endcase
		end
	end

	// effective settings
	logic [3:0]    scale_eff;
	logic [7:0]    cols_eff;
	logic [7:0]    nrows_eff;
	logic [TW-1:0] ts_eff;

	always_comb begin
		if (scale_q == 4'd0)      scale_eff = 4'd1;
		else if (scale_q > 4'd8)  scale_eff = 4'd8;
		else                      scale_eff = scale_q;
		cols_eff  = (columns_q == 8'd0) ? 8'd1 : columns_q;
		nrows_eff = (rows_q == 8'd0) ? 8'd1 : rows_q;
		if (tab_stop_q == 5'd0)                     ts_eff = TW'(1);
		else if (int'(tab_stop_q) > MAX_TAB_STOP)   ts_eff = TW'(MAX_TAB_STOP);
		else                                        ts_eff = TW'(tab_stop_q);
	end

	state_t        state_q;
	logic [7:0]    col_q;
	logic [7:0]    row_q;
	logic [TW-1:0] cnt_q;     // draws still to issue
	logic [6:0]    glyph_q;

	// tab column remainder
	rem_stat_t     rem_stat;
	logic [TW-1:0] rem_val;
	logic          accept;
	logic          rem_start;

	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign rem_start = accept && (s_tdata == CHAR_TAB);

	txcon_rem #(.DW(TW)) u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (rem_start),
		.dividend (col_q),
		.divisor  (ts_eff),
		.stat     (rem_stat),
		.rem      (rem_val)
	);

	// geometry
	logic [11:0] col_mul;
	logic [11:0] row_mul;
	logic [13:0] col_px;
	logic [13:0] row_px;
	logic [6:0]  cell_px;

	assign col_mul = 12'(col_q) * 12'(scale_eff);
	assign row_mul = 12'(row_q) * 12'(scale_eff);
	assign col_px  = {col_mul[10:0], 3'b000};
	assign row_px  = {row_mul[10:0], 3'b000};
	assign cell_px = {scale_eff, 3'b000};

	// cursor step after a draw
	logic [8:0] col_inc;
	logic       wrap;
	logic [8:0] row_nx;
	logic       draw_scroll;
	logic [8:0] nl_row;
	logic       nl_scroll;
	logic [7:0] row_last;

	assign col_inc     = {1'b0, col_q} + 9'd1;
	assign wrap        = col_inc >= {1'b0, cols_eff};
	assign row_nx      = {1'b0, row_q} + 9'(wrap);
	assign draw_scroll = row_nx >= {1'b0, nrows_eff};
	assign nl_row      = {1'b0, row_q} + 9'd1;
	assign nl_scroll   = nl_row >= {1'b0, nrows_eff};
	assign row_last    = nrows_eff - 8'd1;

	logic [6:0] in_glyph;
	assign in_glyph = (s_tdata >= CHAR_FIRST && s_tdata <= CHAR_LAST) ?
		7'(s_tdata - CHAR_FIRST) : GLYPH_FALLBACK;

	// output register
	logic        m_tvalid_q;
	op_t         op_q;
	logic [13:0] px_x_q;
	logic [13:0] px_y_q;
	logic [6:0]  out_glyph_q;
	logic [6:0]  scroll_q;
	logic [31:0] out_fg_q;
	logic [31:0] out_bg_q;
	logic        last_q;
	logic        out_free;
	logic        beat_load;

	assign out_free  = !m_tvalid_q || m_tready;
	// a new command beat enters the output register this cycle
	assign beat_load = out_free &&
		(state_q == ST_DRAW || state_q == ST_SCROLL || state_q == ST_CLEAR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			col_q      <= '0;
			row_q      <= '0;
			cnt_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (beat_load)     m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (s_tdata == CHAR_NL) begin
							col_q <= '0;
							cnt_q <= '0;
							if (nl_scroll) begin
								row_q   <= row_last;
								state_q <= ST_SCROLL;
							end else begin
								row_q <= nl_row[7:0];
							end
						end else if (s_tdata == CHAR_TAB) begin
							glyph_q <= '0;
							state_q <= ST_REM;
						end else begin
							glyph_q <= in_glyph;
							cnt_q   <= TW'(1);
							state_q <= ST_DRAW;
						end
					end
				end
				ST_REM: begin
					if (rem_stat.done) begin
						cnt_q   <= ts_eff - rem_val;
						state_q <= ST_DRAW;
					end
				end
				ST_DRAW: begin
					if (out_free) begin
						op_q        <= OP_DRAW;
						px_x_q      <= col_px;
						px_y_q      <= row_px;
						out_glyph_q <= glyph_q;
						scroll_q    <= '0;
						out_fg_q    <= fg_q;
						out_bg_q    <= bg_q;
						last_q      <= (cnt_q == TW'(1)) && !draw_scroll;
						cnt_q       <= cnt_q - TW'(1);
						col_q       <= wrap ? 8'd0 : col_inc[7:0];
						if (draw_scroll) begin
							row_q   <= row_last;
							state_q <= ST_SCROLL;
						end else begin
							row_q <= row_nx[7:0];
							if (cnt_q == TW'(1)) state_q <= ST_IDLE;
						end
					end
				end
				ST_SCROLL: begin
					if (out_free) begin
						op_q        <= OP_SCROLL;
						px_x_q      <= '0;
						px_y_q      <= '0;
						out_glyph_q <= '0;
						scroll_q    <= cell_px;
						out_fg_q    <= '0;
						out_bg_q    <= '0;
						last_q      <= 1'b0;
						state_q     <= ST_CLEAR;
					end
				end
				ST_CLEAR: begin
					if (out_free) begin
						op_q        <= OP_CLEAR;
						px_x_q      <= '0;
						px_y_q      <= row_px;
						out_glyph_q <= '0;
						scroll_q    <= '0;
						out_fg_q    <= '0;
						out_bg_q    <= bg_q;
						last_q      <= (cnt_q == '0);
						state_q     <= (cnt_q == '0) ? ST_IDLE : ST_DRAW;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = op_q;
	assign m_tlast  = last_q;
	assign m_tdata  = {6'd0, out_bg_q, out_fg_q, scroll_q, out_glyph_q, px_y_q, px_x_q};

	a_draw_has_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAW) |-> (cnt_q != '0))
		else $error("draw state with no draws left");

	a_scroll_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && op_q == OP_SCROLL) |-> (!last_q && scroll_q != '0))
		else $error("scroll beat marked last or empty");

	a_scroll_then_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCROLL && out_free) |=> (state_q == ST_CLEAR))
		else $error("scroll not followed by row clear");

	a_rem_only_in_tab: assert property (@(posedge clk) disable iff (!arst_n)
		rem_stat.done |-> (state_q == ST_REM))
		else $error("remainder result outside tab handling");

endmodule
